[src/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared types and codes for the allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic ST_DONE    = 1'b0;
    localparam logic ST_NO_ROOM = 1'b1;

    localparam int START_W   = 8;
    localparam int COUNT_W   = 8;
    localparam int MAX_START = 255;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_MARK,
        S_FREE,
        S_POST
    } bba_state_t;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic scan_step;
        logic mark_step;
        logic free_step;
        logic post;
    } bba_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic scan_hit;
        logic scan_fail;
        logic range_done;
        logic out_free;
        logic item_free;
    } bba_stat_t;

endpackage

`default_nettype wire

[src/bba_if.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [bba_pkg::START_W-1:0] start_block;
    logic [bba_pkg::COUNT_W-1:0] block_count;

    modport source (output valid, output action, output start_block, output block_count,
                    input ready);
    modport sink   (input valid, input action, input start_block, input block_count,
                    output ready);
endinterface

interface bba_out_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [bba_pkg::START_W-1:0] granted_start;

    modport source (output valid, output status, output granted_start, input ready);
    modport sink   (input valid, input status, input granted_start, output ready);
endinterface

`default_nettype wire

[src/bba_datapath.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator datapath
// Occupancy memory, scan/fill index, run counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath #(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bba_pkg::bba_cmd_t           cmd,
    output bba_pkg::bba_stat_t               stat,
    input  wire logic                        action,
    input  wire logic [bba_pkg::START_W-1:0] start_block,
    input  wire logic [bba_pkg::COUNT_W-1:0] block_count,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             out_status,
    output logic [bba_pkg::START_W-1:0]      out_start
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int IW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam logic [IW-1:0] NB      = IW'(NUM_BLOCKS);
    localparam logic [IW-1:0] NB_LAST = IW'(NUM_BLOCKS - 1);
    localparam logic [IW-1:0] MAXS    = IW'(bba_pkg::MAX_START);

    logic                        map_mem [NUM_BLOCKS];
    logic                        rdata_reg;

    logic [IW-1:0]               idx_reg, idx_next;
    logic [IW-1:0]               chk_idx_reg;
    logic                        chk_valid_reg, chk_valid_next;
    logic [bba_pkg::COUNT_W-1:0] run_reg, run_next;
    logic                        out_valid_reg, out_valid_next;

    logic [IW-1:0]               end_reg;
    logic [bba_pkg::COUNT_W-1:0] count_reg;
    logic                        res_status_reg;
    logic [bba_pkg::START_W-1:0] res_start_reg;
    logic                        out_status_reg;
    logic [bba_pkg::START_W-1:0] out_start_reg;

    logic                        in_range;
    logic [IW-1:0]               sum;
    logic [IW-1:0]               free_end;
    logic [bba_pkg::COUNT_W-1:0] run_inc;
    logic                        hit;
    logic [IW-1:0]               first;
    logic                        first_ok;
    logic                        range_done;
    logic                        we;
    logic                        wdata;

    assign in_range   = idx_reg < NB;
    assign sum        = IW'(start_block) + IW'(block_count);
    assign free_end   = (sum > NB) ? NB : sum;
    assign run_inc    = run_reg + 1'b1;
    assign hit        = chk_valid_reg && !rdata_reg && (count_reg != '0)
                        && (run_inc == count_reg);
    assign first      = chk_idx_reg + 1'b1 - IW'(count_reg);
    assign first_ok   = first <= MAXS;
    assign range_done = idx_reg >= end_reg;

    always_comb
    begin
        stat.clear_last = idx_reg == NB_LAST;
        stat.scan_hit   = hit && first_ok;
        stat.scan_fail  = (hit && !first_ok) || (!chk_valid_reg && !in_range);
        stat.range_done = range_done;
        stat.out_free   = !out_valid_reg || out_ready;
        stat.item_free  = action == bba_pkg::ACT_FREE;
    end

    always_comb
    begin
        we    = 1'b0;
        wdata = 1'b0;
        if (cmd.clear_step)
        begin
            we    = 1'b1;
            wdata = idx_reg == '0;
        end
        else if (cmd.mark_step && !range_done)
        begin
            we    = 1'b1;
            wdata = 1'b1;
        end
        else if (cmd.free_step && !range_done && idx_reg != '0)
        begin
            we    = 1'b1;
            wdata = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            map_mem[idx_reg[AW-1:0]] <= wdata;
        end
        if (cmd.scan_step && in_range)
        begin
            rdata_reg <= map_mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        chk_valid_next = chk_valid_reg;
        run_next       = run_reg;
        out_valid_next = out_valid_reg;

        if (cmd.load)
        begin
            idx_next       = (action == bba_pkg::ACT_FREE) ? IW'(start_block) : '0;
            chk_valid_next = 1'b0;
            run_next       = '0;
        end
        else if (cmd.clear_step)
        begin
            idx_next = (idx_reg == NB_LAST) ? '0 : idx_reg + 1'b1;
        end
        else if (cmd.scan_step)
        begin
            chk_valid_next = in_range;
            if (chk_valid_reg)
            begin
                run_next = rdata_reg ? '0 : run_inc;
            end
            if (hit && first_ok)
            begin
                idx_next = first;
            end
            else if (in_range)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if ((cmd.mark_step || cmd.free_step) && !range_done)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd.post)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            chk_valid_reg <= 1'b0;
            run_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            chk_valid_reg <= chk_valid_next;
            run_reg       <= run_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            count_reg      <= block_count;
            end_reg        <= free_end;
            res_status_reg <= (action == bba_pkg::ACT_FREE) ? bba_pkg::ST_DONE
                                                            : bba_pkg::ST_NO_ROOM;
            res_start_reg  <= '0;
        end
        else if (cmd.scan_step && hit && first_ok)
        begin
            end_reg        <= chk_idx_reg + 1'b1;
            res_status_reg <= bba_pkg::ST_DONE;
            res_start_reg  <= first[bba_pkg::START_W-1:0];
        end
        if (cmd.scan_step)
        begin
            chk_idx_reg <= idx_reg;
        end
        if (cmd.post)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_start  = out_start_reg;

endmodule

`default_nettype wire

[src/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator controller
// Sequences the clearing pass, scan, mark, free and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t       cmd
);

    bba_pkg::bba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            bba_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            bba_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.item_free ? bba_pkg::S_FREE : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_hit)
                begin
                    state_next = bba_pkg::S_MARK;
                end
                else if (stat.scan_fail)
                begin
                    state_next = bba_pkg::S_POST;
                end
            end
            bba_pkg::S_MARK:
            begin
                cmd.mark_step = 1'b1;
                if (stat.range_done)
                begin
                    state_next = bba_pkg::S_POST;
                end
            end
            bba_pkg::S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (stat.range_done)
                begin
                    state_next = bba_pkg::S_POST;
                end
            end
            bba_pkg::S_POST:
            begin
                if (stat.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/bitmap_block_allocator_core.sv]
// ----------------------------------------------------------------------------
// Bitmap block allocator core
// First-fit allocator over an occupancy bitmap of NUM_BLOCKS blocks.
//
//   Channel     Dir   Payload                          Handshake
//   item_in     in    action, start_block, block_count valid/ready
//   result_out  out   status, granted_start            valid/ready
//
// Allocate: scan one bitmap bit per cycle from block 0, then mark the
// block_count granted blocks, with a load step before and a post step after.
// Free: one bitmap write per cycle; block 0 is reserved and never freed.
// After reset a clearing pass over the bitmap runs before item_in.ready.
// A result waiting in the output register stalls only the post step.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bba_in_if.sink    item_in,
    bba_out_if.source result_out
);

    bba_pkg::bba_cmd_t  cmd;
    bba_pkg::bba_stat_t stat;

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .in_ready (item_in.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bba_datapath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (item_in.action),
        .start_block (item_in.start_block),
        .block_count (item_in.block_count),
        .out_valid   (result_out.valid),
        .out_ready   (result_out.ready),
        .out_status  (result_out.status),
        .out_start   (result_out.granted_start)
    );

endmodule

`default_nettype wire
